FILE: rtl/gpio_register_bank_with_set_clear_assert.svh
// assertion macros for the gpio register bank
`ifndef GPIO_REGISTER_BANK_WITH_SET_CLEAR_ASSERT_SVH
`define GPIO_REGISTER_BANK_WITH_SET_CLEAR_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define GRB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gpio register bank check failed");

// next-cycle implication, disabled while reset is asserted
`define GRB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gpio register bank check failed");

`endif

FILE: rtl/gpiorb_pkg.sv
`default_nettype none
package gpiorb_pkg;

	// access kinds on the request channel
	typedef enum logic [1:0] {
		REQ_WORD_RD = 2'd0,
		REQ_WORD_WR = 2'd1,
		REQ_BYTE_RD = 2'd2,
		REQ_BYTE_WR = 2'd3
	} req_t;

	// register targeted by a decoded address
	typedef enum logic [2:0] {
		SEL_OUT,
		SEL_SET,
		SEL_CLR,
		SEL_EN,
		SEL_IN,
		SEL_CTRL,
		SEL_SYS,
		SEL_NONE
	} sel_t;

	// offsets within the gpio block
	localparam logic [31:0] OFS_OUT = 32'h0000_0004;
	localparam logic [31:0] OFS_SET = 32'h0000_0008;
	localparam logic [31:0] OFS_CLR = 32'h0000_000C;
	localparam logic [31:0] OFS_EN  = 32'h0000_0020;
	localparam logic [31:0] OFS_IN  = 32'h0000_003C;

	localparam logic [7:0] BYTE_MASK = 8'hFF;

endpackage
`default_nettype wire

FILE: rtl/gpio_register_bank_with_set_clear.sv
`default_nettype none
// gpio register bank with write-one-to-set and write-one-to-clear
//
// request channel (in_valid/in_ready) carries one bus access per word:
// req_type, address, write_data and the sampled pin_levels
// response channel (out_valid/out_ready) returns one word per access:
// read_data, plus pin_drive and pin_output_enable as they stand after it
//
// a word is captured in the input register, decoded and merged in one
// pass of shallow logic, and then lands in the result register, where
// the bank words are updated at the same edge
// out_valid rises once the word has moved from the input register to the
// result register; throughput is one access per cycle while out_ready is
// held high, held by the single decode and merge pass
//
// reset clears all four bank words and both valid flags; pin_drive and
// pin_output_enable read zero, read_data is undefined until the first word
// when the receiver stalls, the result register holds its word and the
// input register holds the next one; in_ready drops only while both are
// full and out_ready is low
module gpio_register_bank_with_set_clear #(
	parameter logic [31:0] GPIO_BLOCK_BASE   = 32'h3FF4_4000,
	parameter logic [31:0] CONTROL_WORD_ADDR = 32'h3FF4_8000,
	parameter logic [31:0] SYSTEM_WORD_ADDR  = 32'h3FF0_0000
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  req_type,
	input  wire logic [31:0] address,
	input  wire logic [31:0] write_data,
	input  wire logic [31:0] pin_levels,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      read_data,
	output logic [31:0]      pin_drive,
	output logic [31:0]      pin_output_enable
);
	import gpiorb_pkg::*;

	`include "gpio_register_bank_with_set_clear_assert.svh"

	// word addresses of the gpio block, wrapping at 32 bits
	localparam logic [31:0] ADDR_OUT = 32'(GPIO_BLOCK_BASE + OFS_OUT);
	localparam logic [31:0] ADDR_SET = 32'(GPIO_BLOCK_BASE + OFS_SET);
	localparam logic [31:0] ADDR_CLR = 32'(GPIO_BLOCK_BASE + OFS_CLR);
	localparam logic [31:0] ADDR_EN  = 32'(GPIO_BLOCK_BASE + OFS_EN);
	localparam logic [31:0] ADDR_IN  = 32'(GPIO_BLOCK_BASE + OFS_IN);

	// input register
	logic        valid_s1;
	req_t        req_s1;
	logic [31:0] address_s1;
	logic [31:0] write_data_s1;
	logic [31:0] pin_levels_s1;

	// bank words
	logic [31:0] out_level_q;
	logic [31:0] out_enable_q;
	logic [31:0] ctrl_word_q;
	logic [31:0] sys_word_q;

	// result register
	logic        out_valid_q;
	logic [31:0] read_data_q;

	logic        advance;
	logic        is_word;
	logic        is_write;
	logic [31:0] acc_addr;
	sel_t        sel;
	logic [31:0] rd_word;
	logic [7:0]  rd_byte;
	logic [31:0] merged;
	logic [31:0] wr_val;
	logic [31:0] rd_next;
	logic [31:0] out_level_d;
	logic [31:0] out_enable_d;
	logic [31:0] ctrl_word_d;
	logic [31:0] sys_word_d;

	// the input word moves on whenever the result slot is free or being taken
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1        <= req_t'(req_type);
			address_s1    <= address;
			write_data_s1 <= write_data;
			pin_levels_s1 <= pin_levels;
		end
	end

	// word accesses match the full address, byte accesses the aligned word
	assign is_word  = (req_s1 == REQ_WORD_RD) || (req_s1 == REQ_WORD_WR);
	assign is_write = (req_s1 == REQ_WORD_WR) || (req_s1 == REQ_BYTE_WR);
	assign acc_addr = is_word ? address_s1 : {address_s1[31:2], 2'b00};

	// first match in map order wins when addresses overlap
	always_comb begin
		priority if (acc_addr == ADDR_OUT)          sel = SEL_OUT;
		else if (acc_addr == ADDR_SET)              sel = SEL_SET;
		else if (acc_addr == ADDR_CLR)              sel = SEL_CLR;
		else if (acc_addr == ADDR_EN)               sel = SEL_EN;
		else if (acc_addr == ADDR_IN)               sel = SEL_IN;
		else if (acc_addr == CONTROL_WORD_ADDR)     sel = SEL_CTRL;
		else if (acc_addr == SYSTEM_WORD_ADDR)      sel = SEL_SYS;
		else                                        sel = SEL_NONE;
	end

	always_comb begin
		unique case (sel)
			SEL_OUT:  rd_word = out_level_q;
			SEL_EN:   rd_word = out_enable_q;
			SEL_IN:   rd_word = pin_levels_s1;
			SEL_CTRL: rd_word = ctrl_word_q;
			SEL_SYS:  rd_word = sys_word_q;
			default:  rd_word = '0;
		endcase
	end

	// byte lane pick and read-merge for byte writes
	always_comb begin
		merged = rd_word;
		unique case (address_s1[1:0])
			2'd0: begin
				rd_byte      = rd_word[7:0];
				merged[7:0]  = write_data_s1[7:0];
			end
			2'd1: begin
				rd_byte      = rd_word[15:8];
				merged[15:8] = write_data_s1[7:0];
			end
			2'd2: begin
				rd_byte       = rd_word[23:16];
				merged[23:16] = write_data_s1[7:0];
			end
			default: begin
				rd_byte       = rd_word[31:24];
				merged[31:24] = write_data_s1[7:0];
			end
		endcase
	end

	assign wr_val = is_word ? write_data_s1 : merged;

	always_comb begin
		unique case (req_s1)
			REQ_WORD_RD: rd_next = rd_word;
			REQ_BYTE_RD: rd_next = {24'd0, rd_byte & BYTE_MASK};
			default:     rd_next = '0;
		endcase
	end

	// bank update for this access
	always_comb begin
		out_level_d  = out_level_q;
		out_enable_d = out_enable_q;
		ctrl_word_d  = ctrl_word_q;
		sys_word_d   = sys_word_q;
		if (is_write) begin
			unique case (sel)
				SEL_OUT:  out_level_d  = wr_val;
				SEL_SET:  out_level_d  = out_level_q | wr_val;
				SEL_CLR:  out_level_d  = out_level_q & ~wr_val;
				SEL_EN:   out_enable_d = wr_val;
				SEL_CTRL: ctrl_word_d  = wr_val;
				SEL_SYS:  sys_word_d   = wr_val;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_level_q  <= '0;
			out_enable_q <= '0;
			ctrl_word_q  <= '0;
			sys_word_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (advance) begin
				out_level_q  <= out_level_d;
				out_enable_q <= out_enable_d;
				ctrl_word_q  <= ctrl_word_d;
				sys_word_q   <= sys_word_d;
				out_valid_q  <= 1'b1;
			end else if (out_ready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_q <= rd_next;
		end
	end

	assign out_valid         = out_valid_q;
	assign read_data         = read_data_q;
	assign pin_drive         = out_level_q;
	assign pin_output_enable = out_enable_q;

	// writes answer with zero read data
	`GRB_ASSERT_NEXT(a_write_reads_zero, clk, arst_n, advance && is_write, read_data_q == '0)
	// byte reads are zero-extended
	`GRB_ASSERT_NEXT(a_byte_rd_ext, clk, arst_n, advance && (req_s1 == REQ_BYTE_RD),
		read_data_q[31:8] == 24'd0)
	// a waiting input word is never overwritten
	`GRB_ASSERT_NEXT(a_s1_holds, clk, arst_n, valid_s1 && !advance,
		valid_s1 && $stable(address_s1) && $stable(write_data_s1))
	// bank words only change when an access retires
	`GRB_ASSERT_NEXT(a_bank_stable, clk, arst_n, !advance,
		$stable(out_level_q) && $stable(out_enable_q) && $stable(ctrl_word_q)
		&& $stable(sys_word_q))

endmodule
`default_nettype wire

FILE: sim/tb.sv
module tb;
	import gpiorb_pkg::*;

	// address map used for this run, handed to the block as parameters
	localparam logic [31:0] GPIO_BASE = 32'h3FF4_4000;
	localparam logic [31:0] CTRL_ADDR = 32'h3FF4_8000;
	localparam logic [31:0] SYS_ADDR  = 32'h3FF0_0000;

	// cycles without any accepted word before the run is abandoned
	localparam int STALL_LIMIT = 2000;

	// one response word as the block should return it
	typedef struct packed {
		logic [31:0] read_data;
		logic [31:0] pin_drive;
		logic [31:0] pin_output_enable;
	} resp_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	req_t        req_type;
	logic [31:0] address;
	logic [31:0] write_data;
	logic [31:0] pin_levels;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] read_data;
	logic [31:0] pin_drive;
	logic [31:0] pin_output_enable;

	// shadow copy of the bank words
	logic [31:0] drive_word;
	logic [31:0] enable_word;
	logic [31:0] ctrl_word;
	logic [31:0] sys_word;

	// response words predicted for accepted requests, oldest first
	resp_t pending_responses[$];

	int  mismatches;
	int  idle_cycles;
	bit  tx_idle_on;
	bit  rx_idle_on;
	bit  resp_taken;
	bit  hold_req;
	int  hold_len;

	gpio_register_bank_with_set_clear #(
		.GPIO_BLOCK_BASE  (GPIO_BASE),
		.CONTROL_WORD_ADDR(CTRL_ADDR),
		.SYSTEM_WORD_ADDR (SYS_ADDR)
	) i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.req_type         (req_type),
		.address          (address),
		.write_data       (write_data),
		.pin_levels       (pin_levels),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.read_data        (read_data),
		.pin_drive        (pin_drive),
		.pin_output_enable(pin_output_enable)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// prediction
	// ---------------------------------------------------------------

	// which bank word an exact address hits; earlier entries win on overlap
	function automatic sel_t decode_target(input logic [31:0] a);
		if (a == GPIO_BASE + OFS_OUT) return SEL_OUT;
		if (a == GPIO_BASE + OFS_SET) return SEL_SET;
		if (a == GPIO_BASE + OFS_CLR) return SEL_CLR;
		if (a == GPIO_BASE + OFS_EN)  return SEL_EN;
		if (a == GPIO_BASE + OFS_IN)  return SEL_IN;
		if (a == CTRL_ADDR)           return SEL_CTRL;
		if (a == SYS_ADDR)            return SEL_SYS;
		return SEL_NONE;
	endfunction

	// set and clear read back as zero, the input word returns the pins
	function automatic logic [31:0] fetch_word(input sel_t s, input logic [31:0] pins);
		case (s)
			SEL_OUT:  return drive_word;
			SEL_EN:   return enable_word;
			SEL_IN:   return pins;
			SEL_CTRL: return ctrl_word;
			SEL_SYS:  return sys_word;
			default:  return '0;
		endcase
	endfunction

	function automatic void store_word(input sel_t s, input logic [31:0] v);
		case (s)
			SEL_OUT:  drive_word  = v;
			SEL_SET:  drive_word  = drive_word | v;
			SEL_CLR:  drive_word  = drive_word & ~v;
			SEL_EN:   enable_word = v;
			SEL_CTRL: ctrl_word   = v;
			SEL_SYS:  sys_word    = v;
			default: ;
		endcase
	endfunction

	// one bus access against the shadow bank, giving the response word
	function automatic resp_t gpio_access(input req_t rq, input logic [31:0] a,
			input logic [31:0] wd, input logic [31:0] pins);
		logic [31:0] rd;
		logic [31:0] merged;
		logic [31:0] lane_mask;
		logic [31:0] aligned;
		logic [4:0]  sh;
		rd        = '0;
		aligned   = {a[31:2], 2'b00};
		sh        = {a[1:0], 3'b000};
		lane_mask = {24'd0, BYTE_MASK} << sh;
		case (rq)
			REQ_WORD_RD: rd = fetch_word(decode_target(a), pins);
			REQ_WORD_WR: store_word(decode_target(a), wd);
			REQ_BYTE_RD: rd = (fetch_word(decode_target(aligned), pins) >> sh) & {24'd0, BYTE_MASK};
			REQ_BYTE_WR: begin
				// read the aligned word, swap in the lane, write it back
				merged = fetch_word(decode_target(aligned), pins);
				merged = (merged & ~lane_mask) | ({24'd0, wd[7:0]} << sh);
				store_word(decode_target(aligned), merged);
			end
			default: ;
		endcase
		return '{rd, drive_word, enable_word};
	endfunction

	// ---------------------------------------------------------------
	// request side
	// ---------------------------------------------------------------

	// offer one request word after a random gap and wait for it to be taken;
	// valid stays high into the next call when no gap is drawn
	task automatic send_access(input req_t rq, input logic [31:0] ad,
			input logic [31:0] wd, input logic [31:0] pl);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 14) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid   = 1'b0;
			req_type   = req_t'($urandom_range(0, 3));
			address    = $urandom;
			write_data = $urandom;
			pin_levels = $urandom;
			repeat (gap) @(negedge clk);
		end
		in_valid   = 1'b1;
		req_type   = rq;
		address    = ad;
		write_data = wd;
		pin_levels = pl;
		do @(posedge clk); while (!in_ready);
		pending_responses.push_back(gpio_access(rq, ad, wd, pl));
	endtask

	// random access, mostly aimed at mapped words, some anywhere
	task automatic send_random_access();
		int unsigned pick;
		req_t        rq;
		logic [31:0] ad;
		logic [31:0] wd;
		pick = $urandom_range(0, 99);
		rq   = req_t'($urandom_range(0, 3));
		if (pick < 88) begin
			case ($urandom_range(0, 6))
				0:       ad = GPIO_BASE + OFS_OUT;
				1:       ad = GPIO_BASE + OFS_SET;
				2:       ad = GPIO_BASE + OFS_CLR;
				3:       ad = GPIO_BASE + OFS_EN;
				4:       ad = GPIO_BASE + OFS_IN;
				5:       ad = CTRL_ADDR;
				default: ad = SYS_ADDR;
			endcase
			if (rq == REQ_BYTE_RD || rq == REQ_BYTE_WR)
				ad[1:0] = 2'($urandom_range(0, 3));
			else if (pick >= 80)
				ad[1:0] = 2'($urandom_range(1, 3));
		end else begin
			ad = $urandom;
		end
		case ($urandom_range(0, 9))
			0:       wd = '0;
			1:       wd = '1;
			default: wd = $urandom;
		endcase
		send_access(rq, ad, wd, $urandom);
	endtask

	// drop valid and hold off until every predicted word has come back
	task automatic wait_for_responses();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_responses.size() != 0) @(negedge clk);
	endtask

	// ---------------------------------------------------------------
	// response side
	// ---------------------------------------------------------------

	// ready pattern: random gap per word, or a long hold when asked for
	initial begin : response_pacing
		int stall_left;
		int gap;
		stall_left = 0;
		out_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = hold_len;
			end
			if (stall_left > 0) begin
				out_ready  = 1'b0;
				stall_left = stall_left - 1;
			end else if (!out_ready) begin
				out_ready = 1'b1;
			end else if (resp_taken) begin
				gap = rx_idle_on ? $urandom_range(0, 14) : 0;
				if (gap > 0) begin
					out_ready  = 1'b0;
					stall_left = gap - 1;
				end
			end
		end
	end

	task automatic flag_error(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%s", msg);
	endtask

	// compare every accepted response word with the oldest prediction
	always @(posedge clk) begin
		resp_t want;
		resp_taken = arst_n && out_valid && out_ready;
		if (resp_taken) begin
			if (pending_responses.size() == 0) begin
				flag_error($sformatf("unexpected response word: rd %h drive %h oe %h",
					read_data, pin_drive, pin_output_enable));
			end else begin
				want = pending_responses.pop_front();
				if (read_data !== want.read_data)
					flag_error($sformatf("read_data: expected %h, got %h",
						want.read_data, read_data));
				if (pin_drive !== want.pin_drive)
					flag_error($sformatf("pin_drive: expected %h, got %h",
						want.pin_drive, pin_drive));
				if (pin_output_enable !== want.pin_output_enable)
					flag_error($sformatf("pin_output_enable: expected %h, got %h",
						want.pin_output_enable, pin_output_enable));
			end
		end
	end

	// watchdog on cycles where neither channel moves a word
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles = idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// everything reads back zero after reset, the input word shows the pins
	task automatic test_reset_values();
		send_access(REQ_WORD_RD, GPIO_BASE + OFS_OUT, '0, '0);
		send_access(REQ_WORD_RD, GPIO_BASE + OFS_EN, '1, '1);
		send_access(REQ_WORD_RD, CTRL_ADDR, '0, 32'h1234_5678);
		send_access(REQ_WORD_RD, SYS_ADDR, '0, '0);
		send_access(REQ_WORD_RD, GPIO_BASE + OFS_SET, '0, '1);
		send_access(REQ_WORD_RD, GPIO_BASE + OFS_IN, '0, 32'hA5C3_0FF0);
		send_access(REQ_WORD_RD, 32'h0000_0000, '1, '1);
	endtask

	// full-word writes to each register, set/clear, read-only and unaligned
	task automatic test_word_map();
		send_access(REQ_WORD_WR, GPIO_BASE + OFS_OUT, '1, '0);
		send_access(REQ_WORD_WR, GPIO_BASE + OFS_CLR, 32'h0F0F_0F0F, '0);
		send_access(REQ_WORD_WR, GPIO_BASE + OFS_SET, 32'h0000_0001, '1);
		send_access(REQ_WORD_WR, GPIO_BASE + OFS_EN, '1, '0);
		send_access(REQ_WORD_WR, CTRL_ADDR, '1, '0);
		send_access(REQ_WORD_WR, SYS_ADDR, 32'h8000_0001, '0);
		// writes to the input word are dropped
		send_access(REQ_WORD_WR, GPIO_BASE + OFS_IN, '1, '1);
		// word accesses off the exact address miss the map
		send_access(REQ_WORD_WR, GPIO_BASE + OFS_OUT + 1, '0, '0);
		send_access(REQ_WORD_RD, GPIO_BASE + OFS_OUT + 3, '0, '0);
		send_access(REQ_WORD_RD, GPIO_BASE + OFS_OUT, '0, '1);
	endtask

	// byte lanes: reads, merges, set/clear by lane, read-only and unmapped
	task automatic test_byte_lanes();
		send_access(REQ_BYTE_RD, GPIO_BASE + OFS_IN + 3, '0, 32'hC300_0000);
		send_access(REQ_BYTE_WR, GPIO_BASE + OFS_OUT + 2, 32'hFFFF_FF00, '0);
		send_access(REQ_BYTE_WR, GPIO_BASE + OFS_SET + 1, 32'h0000_00FF, '0);
		send_access(REQ_BYTE_WR, GPIO_BASE + OFS_CLR, 32'h0000_00FF, '1);
		send_access(REQ_BYTE_WR, GPIO_BASE + OFS_IN, 32'h0000_005A, '1);
		send_access(REQ_BYTE_RD, GPIO_BASE + OFS_EN + 1, '0, '0);
		send_access(REQ_BYTE_WR, 32'hFFFF_FFFF, '1, '1);
	endtask

	// receiver holds off while requests keep coming, so the pipe fills
	task automatic test_stall_fill();
		tx_idle_on = 1'b0;
		@(posedge clk);
		hold_len = 150;
		hold_req = 1'b1;
		repeat (30) send_random_access();
		wait_for_responses();
		tx_idle_on = 1'b1;
	endtask

	// long random run in stretches with different idle patterns
	task automatic test_random_accesses(input int count);
		int unsigned mode;
		for (int i = 0; i < count; i++) begin
			if (i % 250 == 0) begin
				case (i / 250)
					0:       mode = 3;
					1:       mode = 0;
					default: mode = $urandom_range(0, 3);
				endcase
				tx_idle_on = mode[0];
				rx_idle_on = mode[1];
			end
			send_random_access();
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		req_type    = REQ_WORD_RD;
		address     = '0;
		write_data  = '0;
		pin_levels  = '0;
		mismatches  = 0;
		idle_cycles = 0;
		tx_idle_on  = 1'b1;
		rx_idle_on  = 1'b1;
		resp_taken  = 1'b0;
		hold_req    = 1'b0;
		hold_len    = 0;
		drive_word  = '0;
		enable_word = '0;
		ctrl_word   = '0;
		sys_word    = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_values();
		test_word_map();
		test_byte_lanes();
		// sender pause until the directed words are all back
		wait_for_responses();
		test_stall_fill();
		test_random_accesses(1500);

		wait_for_responses();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_responses.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
